// ----- sv/alignment_column_count_gap_stats_macros.svh -----
// Assertion macros for the column gap statistics block.
`ifndef ALIGNMENT_COLUMN_COUNT_GAP_STATS_MACROS_SVH
`define ALIGNMENT_COLUMN_COUNT_GAP_STATS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACGS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("acgs: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ACGS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("acgs: next-cycle check failed");

`endif

// ----- sv/acgs_pkg.sv -----
// Shared constants, types and helper functions for the column gap statistics block.
`timescale 1ns / 1ps
package acgs_pkg;

    localparam int MAX_READS = 1024;
    localparam int COUNT_W   = 11;
    localparam int NUM_SYMS  = 5;
    localparam int NUM_GAPS  = 4;
    localparam int PCT_W     = 7;
    localparam int DIV_STEPS = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] DIV_MAX   =
        COUNT_W'((MAX_READS > 2047) ? 2047 : MAX_READS);
    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_C   = 8'h43;
    localparam logic [7:0] CHAR_T   = 8'h54;
    localparam logic [7:0] CHAR_G   = 8'h47;
    localparam logic [7:0] CHAR_GAP = 8'h2D;

    typedef logic [COUNT_W-1:0] count_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       count_en;   // item accepted: count its symbol
        logic       col_close;  // hand counts to the sorter and clear them
        logic       sort_en;    // one transposition phase
        logic       sort_odd;   // odd phase when set
        logic       gap_update; // fold neighbor gaps into the trackers
        logic       div_load;   // load both dividers for the current rank
        logic       div_step;   // one quotient bit
        logic [2:0] div_shift;  // quotient bit position
        logic [1:0] rank;       // rank being reported
        logic       emit;       // capture a result
        logic       last;       // final result of the run
        logic       reload;     // restart trackers after the run
    } cmd_t;

    // Effective divisor: clamp to the supported read count, zero reads as one
    function automatic count_t acgs_divisor(input count_t rc);
        count_t d;
        d = rc;
        if (d > DIV_MAX) d = DIV_MAX;
        if (d == '0) d = count_t'(1);
        return d;
    endfunction

endpackage

// ----- sv/acgs_div.sv -----
// Restoring divider: value * 100 / divisor, saturated at 100, one bit per step.
`timescale 1ns / 1ps
module acgs_div
    import acgs_pkg::*;
(
    input  logic                   clk,
    input  logic                   load,
    input  logic                   step,
    input  logic [2:0]             shift,
    input  count_t                 value,
    input  count_t                 divisor,
    output logic [PCT_W-1:0]       percent
);

    logic [16:0]      rem_reg, rem_next;
    logic [PCT_W-1:0] quo_reg, quo_next;
    logic             sat_reg, sat_next;
    logic [16:0]      value_x;
    logic [16:0]      div_shifted;
    logic [17:0]      trial;

    assign value_x     = {6'b0, value};
    assign div_shifted = {6'b0, divisor} << shift;
    assign trial       = {1'b0, rem_reg} - {1'b0, div_shifted};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        sat_next = sat_reg;
        if (load)
        begin
            // value >= divisor means 100 percent or more; the product may wrap then
            sat_next = (value >= divisor);
            rem_next = (value_x << 6) + (value_x << 5) + (value_x << 2);
            quo_next = '0;
        end
        else if (step)
        begin
            if (!trial[17])
            begin
                rem_next        = trial[16:0];
                quo_next[shift] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign percent = sat_reg ? PCT_FULL : quo_reg;

endmodule

// ----- sv/acgs_datapath.sv -----
// Datapath: symbol counters, sorter, gap trackers, dividers and result registers.
`timescale 1ns / 1ps
module acgs_datapath
    import acgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [7:0]       symbol,
    input  logic             cfg_write,
    input  logic [10:0]      cfg_wdata,
    output logic             result_strobe,
    output logic [1:0]       slot_number,
    output logic [1:0]       rank_gap_index,
    output logic [PCT_W-1:0] min_percent,
    output logic [PCT_W-1:0] max_percent,
    output logic             last_result
);

    count_t           read_count_reg;
    count_t           counts_reg  [NUM_SYMS];
    count_t           counts_inc  [NUM_SYMS];
    count_t           sort_reg    [NUM_SYMS];
    count_t           sort_next   [NUM_SYMS];
    count_t           gap_min_reg [NUM_GAPS];
    count_t           gap_max_reg [NUM_GAPS];
    count_t           gap_val     [NUM_GAPS];
    count_t           divisor;
    logic [1:0]       slot_counter_reg;
    logic             strobe_reg;
    logic [1:0]       slot_out_reg;
    logic [1:0]       rank_out_reg;
    logic [PCT_W-1:0] min_out_reg;
    logic [PCT_W-1:0] max_out_reg;
    logic             last_out_reg;
    logic             sym_hit;
    logic [2:0]       sym_slot;
    logic [PCT_W-1:0] min_pct;
    logic [PCT_W-1:0] max_pct;

    assign divisor = acgs_divisor(read_count_reg);

    always_comb
    begin
        sym_hit  = 1'b1;
        sym_slot = 3'd0;
        case (symbol)
            CHAR_A:   sym_slot = 3'd0;
            CHAR_C:   sym_slot = 3'd1;
            CHAR_T:   sym_slot = 3'd2;
            CHAR_G:   sym_slot = 3'd3;
            CHAR_GAP: sym_slot = 3'd4;
            default:  sym_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SYMS; i++)
        begin
            counts_inc[i] = counts_reg[i];
            if (cmd.count_en && sym_hit && (sym_slot == 3'(i)) && (counts_reg[i] != COUNT_MAX))
                counts_inc[i] = counts_reg[i] + count_t'(1);
        end
    end

    // Odd-even transposition: even phase orders (0,1),(2,3); odd phase (1,2),(3,4)
    always_comb
    begin
        for (int i = 0; i < NUM_SYMS; i++)
            sort_next[i] = sort_reg[i];
        if (cmd.sort_odd)
        begin
            if (sort_reg[1] > sort_reg[2])
            begin
                sort_next[1] = sort_reg[2];
                sort_next[2] = sort_reg[1];
            end
            if (sort_reg[3] > sort_reg[4])
            begin
                sort_next[3] = sort_reg[4];
                sort_next[4] = sort_reg[3];
            end
        end
        else
        begin
            if (sort_reg[0] > sort_reg[1])
            begin
                sort_next[0] = sort_reg[1];
                sort_next[1] = sort_reg[0];
            end
            if (sort_reg[2] > sort_reg[3])
            begin
                sort_next[2] = sort_reg[3];
                sort_next[3] = sort_reg[2];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_GAPS; i++)
            gap_val[i] = sort_reg[i+1] - sort_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_count_reg   <= count_t'(1);
            slot_counter_reg <= '0;
            strobe_reg       <= 1'b0;
            for (int i = 0; i < NUM_SYMS; i++)
                counts_reg[i] <= '0;
            for (int i = 0; i < NUM_GAPS; i++)
            begin
                gap_min_reg[i] <= count_t'(1);
                gap_max_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.emit)
                slot_counter_reg <= slot_counter_reg + 2'd1;

            // Hand the finished column to the sorter and clear for the next
            for (int i = 0; i < NUM_SYMS; i++)
                counts_reg[i] <= cmd.col_close ? '0 : counts_inc[i];

            if (cfg_write)
            begin
                read_count_reg <= cfg_wdata;
                for (int i = 0; i < NUM_GAPS; i++)
                begin
                    gap_min_reg[i] <= acgs_divisor(cfg_wdata);
                    gap_max_reg[i] <= '0;
                end
            end
            else if (cmd.reload)
            begin
                for (int i = 0; i < NUM_GAPS; i++)
                begin
                    gap_min_reg[i] <= divisor;
                    gap_max_reg[i] <= '0;
                end
            end
            else if (cmd.gap_update)
            begin
                for (int i = 0; i < NUM_GAPS; i++)
                begin
                    if (gap_val[i] > gap_max_reg[i])
                        gap_max_reg[i] <= gap_val[i];
                    if (gap_val[i] < gap_min_reg[i])
                        gap_min_reg[i] <= gap_val[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col_close)
        begin
            for (int i = 0; i < NUM_SYMS; i++)
                sort_reg[i] <= counts_inc[i];
        end
        else if (cmd.sort_en)
        begin
            for (int i = 0; i < NUM_SYMS; i++)
                sort_reg[i] <= sort_next[i];
        end

        if (cmd.emit)
        begin
            slot_out_reg <= slot_counter_reg;
            rank_out_reg <= cmd.rank;
            min_out_reg  <= min_pct;
            max_out_reg  <= max_pct;
            last_out_reg <= cmd.last;
        end
    end

    acgs_div u_div_min (
        .clk     (clk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .shift   (cmd.div_shift),
        .value   (gap_min_reg[cmd.rank]),
        .divisor (divisor),
        .percent (min_pct)
    );

    acgs_div u_div_max (
        .clk     (clk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .shift   (cmd.div_shift),
        .value   (gap_max_reg[cmd.rank]),
        .divisor (divisor),
        .percent (max_pct)
    );

    assign result_strobe  = strobe_reg;
    assign slot_number    = slot_out_reg;
    assign rank_gap_index = rank_out_reg;
    assign min_percent    = min_out_reg;
    assign max_percent    = max_out_reg;
    assign last_result    = last_out_reg;

endmodule

// ----- sv/acgs_ctrl.sv -----
// Controller: sequences counting, column sort, tracker update and result division.
`timescale 1ns / 1ps
module acgs_ctrl
    import acgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic column_end,
    input  logic alignment_end,
    output logic busy,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_GAPS,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [2:0] phase_reg;
    logic [2:0] step_reg;
    logic [1:0] rank_reg;
    logic       aln_reg;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        cmd           = '0;
        cmd.count_en  = accept;
        cmd.col_close = accept && (column_end || alignment_end);
        cmd.sort_odd  = phase_reg[0];
        cmd.div_shift = step_reg;
        cmd.rank      = rank_reg;
        cmd.last      = (rank_reg == 2'd0);
        case (state_reg)
            ST_IDLE:     ;
            ST_SORT:     cmd.sort_en    = 1'b1;
            ST_GAPS:     cmd.gap_update = 1'b1;
            ST_DIV_LOAD: cmd.div_load   = 1'b1;
            ST_DIV_STEP: cmd.div_step   = 1'b1;
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.reload = (rank_reg == 2'd0);
            end
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            step_reg  <= '0;
            rank_reg  <= '0;
            aln_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (column_end || alignment_end))
                    begin
                        state_reg <= ST_SORT;
                        phase_reg <= '0;
                        aln_reg   <= alignment_end;
                    end
                end
                ST_SORT:
                begin
                    phase_reg <= phase_reg + 3'd1;
                    if (phase_reg == 3'(NUM_SYMS - 1))
                        state_reg <= ST_GAPS;
                end
                ST_GAPS:
                begin
                    rank_reg  <= 2'(NUM_GAPS - 1);
                    state_reg <= aln_reg ? ST_DIV_LOAD : ST_IDLE;
                end
                ST_DIV_LOAD:
                begin
                    step_reg  <= 3'(DIV_STEPS - 1);
                    state_reg <= ST_DIV_STEP;
                end
                ST_DIV_STEP:
                begin
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    rank_reg <= rank_reg - 2'd1;
                    // Walk ranks from the top gap (between the two largest counts) down
                    state_reg <= (rank_reg == 2'd0) ? ST_IDLE : ST_DIV_LOAD;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/alignment_column_count_gap_stats.sv -----
// Top level of the alignment column gap statistics block.
`timescale 1ns / 1ps
// An item is one alignment character, taken when start is high and busy is low.
// A character that ends no column leaves busy low. A column end raises busy for
// 5 odd-even transposition phases of the count sorter and one tracker update.
// An alignment end then adds, for each of the four ranks, a pass of the shared
// restoring dividers (load, 7 quotient bits, capture). Each result is on the
// outputs for one cycle with result_strobe high, ranks 3 down to 0; the
// receiver cannot hold them off, so capture every strobe. Write cfg_wdata only
// while the block is idle; the write restarts the min and max trackers.
`include "alignment_column_count_gap_stats_macros.svh"
module alignment_column_count_gap_stats
    import acgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  symbol,
    input  logic        column_end,
    input  logic        alignment_end,
    input  logic        cfg_write,
    input  logic [10:0] cfg_wdata,
    output logic        result_strobe,
    output logic [1:0]  slot_number,
    output logic [1:0]  rank_gap_index,
    output logic [6:0]  min_percent,
    output logic [6:0]  max_percent,
    output logic        last_result
);

    cmd_t cmd;

    acgs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .column_end    (column_end),
        .alignment_end (alignment_end),
        .busy          (busy),
        .cmd           (cmd)
    );

    acgs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .symbol         (symbol),
        .cfg_write      (cfg_write),
        .cfg_wdata      (cfg_wdata),
        .result_strobe  (result_strobe),
        .slot_number    (slot_number),
        .rank_gap_index (rank_gap_index),
        .min_percent    (min_percent),
        .max_percent    (max_percent),
        .last_result    (last_result)
    );

    `ACGS_ASSERT_NOW(a_pct_range, clk, rst_n, result_strobe,
        (min_percent <= PCT_FULL) && (max_percent <= PCT_FULL))
    `ACGS_ASSERT_NEXT(a_close_busy, clk, rst_n, start && !busy && (column_end || alignment_end),
        busy)
    `ACGS_ASSERT_NOW(a_mid_run_busy, clk, rst_n, result_strobe && !last_result, busy)
    `ACGS_ASSERT_NOW(a_last_rank, clk, rst_n, result_strobe && last_result,
        rank_gap_index == 2'd0)
    `ACGS_ASSERT_NEXT(a_strobe_gap, clk, rst_n, result_strobe, !result_strobe)

endmodule

// ----- tb/sv/alignment_column_count_gap_stats_checker.sv -----
// Checker for the column gap statistics block: predicts every result line and compares it.
`timescale 1ns / 1ps
module alignment_column_count_gap_stats_checker
    import acgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  symbol,
    input  logic        column_end,
    input  logic        alignment_end,
    input  logic        cfg_write,
    input  logic [10:0] cfg_wdata,
    input  logic        result_strobe,
    input  logic [1:0]  slot_number,
    input  logic [1:0]  rank_gap_index,
    input  logic [6:0]  min_percent,
    input  logic [6:0]  max_percent,
    input  logic        last_result,
    output int          items_taken,
    output int          lines_pending,
    output int          failures
);

    typedef struct {
        logic [1:0] slot;
        logic [1:0] rank;
        logic [6:0] min_pct;
        logic [6:0] max_pct;
        logic       last;
    } gap_line_t;

    gap_line_t   lines_due [$];
    gap_line_t   oldest_due;
    logic [10:0] reads_reg;
    count_t      sym_count [NUM_SYMS];
    count_t      rank_min [NUM_GAPS];
    count_t      rank_max [NUM_GAPS];
    logic [1:0]  line_serial;

    function automatic count_t eff_divisor();
        count_t d;
        d = reads_reg;
        if (d > count_t'(MAX_READS))
            d = count_t'(MAX_READS);
        if (d == '0)
            d = count_t'(1);
        return d;
    endfunction

    function automatic logic [6:0] pct_of(input count_t v);
        int unsigned p;
        p = (int'(v) * 100) / int'(eff_divisor());
        if (p > 100)
            p = 100;
        return p[6:0];
    endfunction

    function automatic void restart_trackers();
        for (int i = 0; i < NUM_GAPS; i++)
        begin
            rank_min[i] = eff_divisor();
            rank_max[i] = '0;
        end
    endfunction

    // Sort the five counts ascending and fold the neighbor gaps into the trackers.
    function automatic void close_column();
        count_t srt [NUM_SYMS];
        count_t tmp;
        count_t g;
        for (int i = 0; i < NUM_SYMS; i++)
            srt[i] = sym_count[i];
        for (int i = 1; i < NUM_SYMS; i++)
            for (int j = i; j > 0 && srt[j-1] > srt[j]; j--)
            begin
                tmp      = srt[j];
                srt[j]   = srt[j-1];
                srt[j-1] = tmp;
            end
        for (int i = 0; i < NUM_GAPS; i++)
        begin
            g = srt[i+1] - srt[i];
            if (g > rank_max[i])
                rank_max[i] = g;
            if (g < rank_min[i])
                rank_min[i] = g;
        end
        for (int i = 0; i < NUM_SYMS; i++)
            sym_count[i] = '0;
    endfunction

    function automatic void take_char(input logic [7:0] s, input logic ce, input logic ae);
        int        slot_idx;
        gap_line_t due;
        slot_idx = -1;
        case (s)
            CHAR_A:   slot_idx = 0;
            CHAR_C:   slot_idx = 1;
            CHAR_T:   slot_idx = 2;
            CHAR_G:   slot_idx = 3;
            CHAR_GAP: slot_idx = 4;
            default:  slot_idx = -1;
        endcase
        if (slot_idx >= 0 && sym_count[slot_idx] != COUNT_MAX)
            sym_count[slot_idx]++;
        if (ce || ae)
            close_column();
        if (ae)
        begin
            for (int k = 0; k < NUM_GAPS; k++)
            begin
                due.slot    = line_serial;
                due.rank    = 2'(3 - k);
                due.min_pct = pct_of(rank_min[3-k]);
                due.max_pct = pct_of(rank_max[3-k]);
                due.last    = (k == 3);
                lines_due.push_back(due);
                line_serial++;
            end
            restart_trackers();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_reg   = 11'd1;
            line_serial = '0;
            for (int i = 0; i < NUM_SYMS; i++)
                sym_count[i] = '0;
            restart_trackers();
            lines_due.delete();
            items_taken   = 0;
            lines_pending = 0;
            failures      = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (lines_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result line: slot %0d rank %0d min %0d max %0d",
                                 slot_number, rank_gap_index, min_percent, max_percent);
                    failures++;
                end
                else
                begin
                    oldest_due = lines_due.pop_front();
                    if (slot_number !== oldest_due.slot || rank_gap_index !== oldest_due.rank ||
                        min_percent !== oldest_due.min_pct ||
                        max_percent !== oldest_due.max_pct || last_result !== oldest_due.last)
                    begin
                        if (failures < 10)
                        begin
                            $display("expected slot %0d rank %0d min %0d max %0d last %0d",
                                     oldest_due.slot, oldest_due.rank, oldest_due.min_pct,
                                     oldest_due.max_pct, oldest_due.last);
                            $display("  actual slot %0d rank %0d min %0d max %0d last %0d",
                                     slot_number, rank_gap_index, min_percent, max_percent,
                                     last_result);
                        end
                        failures++;
                    end
                end
            end
            if (cfg_write)
            begin
                reads_reg = cfg_wdata;
                restart_trackers();
            end
            if (start && !busy)
            begin
                take_char(symbol, column_end, alignment_end);
                items_taken++;
            end
            lines_pending = lines_due.size();
        end
    end

endmodule

// ----- tb/sv/alignment_column_count_gap_stats_test.sv -----
// Testbench top for the column gap statistics block: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps
module alignment_column_count_gap_stats_test
    import acgs_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  symbol;
    logic        column_end;
    logic        alignment_end;
    logic        cfg_write;
    logic [10:0] cfg_wdata;
    logic        result_strobe;
    logic [1:0]  slot_number;
    logic [1:0]  rank_gap_index;
    logic [6:0]  min_percent;
    logic [6:0]  max_percent;
    logic        last_result;

    int          items_taken;
    int          lines_pending;
    int          failures;
    int          sent;
    bit          steady;
    logic [10:0] reads;

    alignment_column_count_gap_stats i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .symbol         (symbol),
        .column_end     (column_end),
        .alignment_end  (alignment_end),
        .cfg_write      (cfg_write),
        .cfg_wdata      (cfg_wdata),
        .result_strobe  (result_strobe),
        .slot_number    (slot_number),
        .rank_gap_index (rank_gap_index),
        .min_percent    (min_percent),
        .max_percent    (max_percent),
        .last_result    (last_result)
    );

    alignment_column_count_gap_stats_checker i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .symbol         (symbol),
        .column_end     (column_end),
        .alignment_end  (alignment_end),
        .cfg_write      (cfg_write),
        .cfg_wdata      (cfg_wdata),
        .result_strobe  (result_strobe),
        .slot_number    (slot_number),
        .rank_gap_index (rank_gap_index),
        .min_percent    (min_percent),
        .max_percent    (max_percent),
        .last_result    (last_result),
        .items_taken    (items_taken),
        .lines_pending  (lines_pending),
        .failures       (failures)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] pick_symbol(input int noise_pct);
        logic [7:0] s;
        case ($urandom_range(4))
            0:       s = CHAR_A;
            1:       s = CHAR_C;
            2:       s = CHAR_T;
            3:       s = CHAR_G;
            default: s = CHAR_GAP;
        endcase
        if ($urandom_range(99) < noise_pct)
            s = 8'($urandom_range(255));
        return s;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_char(input logic [7:0] s, input logic ce, input logic ae);
        int taken;
        while (!steady && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        taken = items_taken;
        start         <= 1'b1;
        symbol        <= s;
        column_end    <= ce;
        alignment_end <= ae;
        do
            @(negedge clk);
        while (items_taken == taken);
        sent++;
    endtask

    task automatic send_column(input int n, input logic ae, input int noise_pct);
        for (int i = 0; i < n; i++)
            send_char(pick_symbol(noise_pct), i == n - 1, ae && (i == n - 1));
    endtask

    // Drop start, drain all result lines, then give a column end time to finish.
    task automatic settle();
        start <= 1'b0;
        while (lines_pending != 0 || busy)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reads(input logic [10:0] v);
        settle();
        reads     = v;
        cfg_wdata <= v;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int cols;
        int len;
        rst_n         = 1'b0;
        start         = 1'b0;
        symbol        = '0;
        column_end    = 1'b0;
        alignment_end = 1'b0;
        cfg_write     = 1'b0;
        cfg_wdata     = '0;
        sent          = 0;
        steady        = 1'b0;
        reads         = 11'd1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // alignment end without column end, on the reset register value
        send_char(CHAR_A, 1'b0, 1'b1);
        write_reads(11'd3);
        send_char(CHAR_A, 1'b0, 1'b0);
        send_char(CHAR_C, 1'b0, 1'b0);
        send_char(CHAR_T, 1'b1, 1'b0);
        send_char(CHAR_GAP, 1'b0, 1'b0);
        send_char(CHAR_GAP, 1'b0, 1'b0);
        send_char(CHAR_GAP, 1'b1, 1'b1);
        // zero read count divides by one
        write_reads(11'd0);
        send_char(CHAR_G, 1'b0, 1'b0);
        send_char(CHAR_G, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        // a column of ignored bytes only leaves all counts at zero
        write_reads(11'd2);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(CHAR_C, 1'b0, 1'b0);
        send_char(CHAR_T, 1'b1, 1'b1);
        // register write inside an alignment restarts the trackers, keeps the counts
        write_reads(11'd5);
        send_char(CHAR_A, 1'b1, 1'b0);
        send_char(CHAR_C, 1'b0, 1'b0);
        write_reads(11'd2);
        send_char(CHAR_G, 1'b1, 1'b0);
        send_char(CHAR_A, 1'b0, 1'b0);
        send_char(CHAR_A, 1'b1, 1'b1);
        // column longer than the read count: percentages clip
        write_reads(11'd1);
        for (int i = 0; i < 6; i++)
            send_char(CHAR_A, 1'b0, i == 5);
        // read counts at and above the supported maximum
        write_reads(11'd2047);
        send_column(5, 1'b1, 0);
        write_reads(11'd1024);
        send_column(4, 1'b1, 0);

        while (sent < 370)
        begin
            steady = (sent >= 120 && sent < 220);
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(9))
                    0:       write_reads(11'd0);
                    1:       write_reads(11'd1024);
                    2:       write_reads(11'($urandom_range(2047)));
                    default: write_reads(11'($urandom_range(1, 8)));
                endcase
            end
            len = (reads >= 1 && reads <= 8) ? int'(reads) : $urandom_range(1, 8);
            case ($urandom_range(9))
                7:
                begin
                    // ragged columns, then an alignment end that closes an open column
                    cols = $urandom_range(1, 3);
                    for (int c = 0; c < cols; c++)
                        send_column($urandom_range(1, 10), 1'b0, 20);
                    send_char(pick_symbol(20), 1'b0, 1'b1);
                end
                8:
                begin
                    repeat ($urandom_range(1, 12))
                        send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                                  $urandom_range(7) == 0);
                end
                default:
                begin
                    cols = $urandom_range(1, 4);
                    for (int c = 0; c < cols; c++)
                        send_column(len, c == cols - 1, 10);
                end
            endcase
        end
        steady = 1'b0;
        settle();

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/acgs_pkg.sv
sv/acgs_div.sv
sv/acgs_datapath.sv
sv/acgs_ctrl.sv
sv/alignment_column_count_gap_stats.sv
tb/sv/alignment_column_count_gap_stats_checker.sv
tb/sv/alignment_column_count_gap_stats_test.sv
